### src/assert_macros.svh
// Assertion macros for the dense layer engine; included by the sequencer module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DLTE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dlte assertion failed");
`define DLTE_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("dlte forbidden condition seen");
`else
`define DLTE_ASSERT(label, clk, rst_n, prop)
`define DLTE_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

### src/dlte_pkg.sv
// Shared types, codes and saturation helpers for the dense layer engine.
`default_nettype none
package dlte_pkg;
    localparam int DEF_MAX_IN  = 1024;
    localparam int DEF_MAX_OUT = 16;
    localparam int ROW_IDX_W   = 7;
    localparam int COL_IDX_W   = 13;
    localparam int VAL_W       = 16;
    localparam int ACC_W       = 48;
    localparam int WG_W        = 32;
    localparam int LR_W        = 16;
    localparam int PRODU_W     = 49;

    localparam logic [2:0] REQ_LDW  = 3'd0;
    localparam logic [2:0] REQ_LDB  = 3'd1;
    localparam logic [2:0] REQ_FWD  = 3'd2;
    localparam logic [2:0] REQ_BWD  = 3'd3;
    localparam logic [2:0] REQ_IGRD = 3'd4;
    localparam logic [2:0] REQ_UPD  = 3'd5;

    localparam logic [1:0] KIND_FWD   = 2'd0;
    localparam logic [1:0] KIND_IGRAD = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    localparam logic [1:0] CFG_IN_SIZE  = 2'd0;
    localparam logic [1:0] CFG_OUT_SIZE = 2'd1;
    localparam logic [1:0] CFG_LR       = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE, OP_LDW, OP_LDB, OP_FWD, OP_FOUT, OP_BWD,
        OP_IGRD, OP_UPD, OP_UBIAS, OP_CLR, OP_DONE
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [1:0]           phase;
        logic [ROW_IDX_W-1:0] row;
        logic [COL_IDX_W-1:0] col;
        logic                 first;
        logic                 zero;
        logic                 inr;
        logic                 last;
        logic                 take;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } stat_t;

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767)
            r = 16'sh7FFF;
        else if (v < -64'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction
endpackage
`default_nettype wire

### src/dlte_ctrl.sv
// Sequencer for the dense layer engine: request decode and element sweeps.
`default_nettype none
`include "assert_macros.svh"
module dlte_ctrl
    import dlte_pkg::*;
#(
    parameter int MAX_IN  = DEF_MAX_IN,
    parameter int MAX_OUT = DEF_MAX_OUT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [2:0] req,
    input  wire logic [3:0] row_in,
    input  wire logic [9:0] col_in,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire stat_t      stat,
    output cmd_t            cmd
);
    localparam int RIW = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
    localparam int CIW = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_FWD   = 4'd2;
    localparam logic [3:0] S_FOUT  = 4'd3;
    localparam logic [3:0] S_BWD   = 4'd4;
    localparam logic [3:0] S_IGRD  = 4'd5;
    localparam logic [3:0] S_UPD   = 4'd6;
    localparam logic [3:0] S_UBIAS = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]     state_reg, state_next;
    logic [RIW-1:0] i_reg, i_next, row_reg, row_next;
    logic [CIW-1:0] j_reg, j_next, col_reg, col_next;
    logic [1:0]     ph_reg, ph_next;
    logic [10:0]    in_size_reg;
    logic [4:0]     out_size_reg;

    logic [COL_IDX_W-1:0] ni, in_ext, col_ext, jend;
    logic [ROW_IDX_W-1:0] no, out_ext, row_ext;
    logic                 acc_req;

    // clamp the size registers to the legal ranges
    always_comb
    begin
        in_ext  = COL_IDX_W'(in_size_reg);
        out_ext = ROW_IDX_W'(out_size_reg);
        if (in_ext == '0)
            ni = COL_IDX_W'(1);
        else if (in_ext > COL_IDX_W'(MAX_IN))
            ni = COL_IDX_W'(MAX_IN);
        else
            ni = in_ext;
        if (out_ext == '0)
            no = ROW_IDX_W'(1);
        else if (out_ext > ROW_IDX_W'(MAX_OUT))
            no = ROW_IDX_W'(MAX_OUT);
        else
            no = out_ext;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign acc_req  = s_tvalid && s_tready;
    assign col_ext  = COL_IDX_W'(col_in);
    assign row_ext  = ROW_IDX_W'(row_in);
    assign jend     = (row_reg == '0) ? COL_IDX_W'(MAX_IN - 1) : ni - 1'b1;

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        ph_next    = ph_reg;
        cmd        = '0;
        cmd.op     = OP_NONE;
        cmd.phase  = ph_reg;
        cmd.row    = ROW_IDX_W'(i_reg);
        cmd.col    = COL_IDX_W'(j_reg);
        unique case (state_reg)
            S_CLR:
            begin
                cmd.op = OP_CLR;
                if (j_reg == CIW'(MAX_IN - 1))
                begin
                    j_next = '0;
                    if (i_reg == RIW'(MAX_OUT - 1))
                    begin
                        i_next     = '0;
                        state_next = S_IDLE;
                    end
                    else
                        i_next = i_reg + 1'b1;
                end
                else
                    j_next = j_reg + 1'b1;
            end
            S_IDLE:
            begin
                cmd.row  = row_ext;
                cmd.col  = col_ext;
                cmd.take = acc_req;
                i_next   = '0;
                j_next   = '0;
                ph_next  = '0;
                if (acc_req)
                begin
                    unique case (req)
                        REQ_LDW:
                            if (row_ext < ROW_IDX_W'(MAX_OUT) && col_ext < COL_IDX_W'(MAX_IN))
                                cmd.op = OP_LDW;
                        REQ_LDB:
                            if (row_ext < ROW_IDX_W'(MAX_OUT))
                                cmd.op = OP_LDB;
                        REQ_FWD:
                            if (col_ext < ni)
                            begin
                                col_next   = CIW'(col_in);
                                state_next = S_FWD;
                            end
                        REQ_BWD:
                            if (row_ext < no)
                            begin
                                row_next   = RIW'(row_in);
                                state_next = S_BWD;
                            end
                        REQ_IGRD:
                            if (col_ext < ni)
                            begin
                                col_next   = CIW'(col_in);
                                state_next = S_IGRD;
                            end
                        REQ_UPD:
                            state_next = S_UPD;
                        default: ;
                    endcase
                end
            end
            S_FWD:
            begin
                cmd.op    = OP_FWD;
                cmd.col   = COL_IDX_W'(col_reg);
                cmd.first = (i_reg == '0);
                cmd.zero  = (col_reg == '0);
                if (ph_reg != 2'd2)
                    ph_next = ph_reg + 1'b1;
                else
                begin
                    ph_next = '0;
                    if (ROW_IDX_W'(i_reg) == no - 1'b1)
                    begin
                        i_next     = '0;
                        state_next = (COL_IDX_W'(col_reg) == ni - 1'b1) ? S_FOUT : S_IDLE;
                    end
                    else
                        i_next = i_reg + 1'b1;
                end
            end
            S_FOUT:
            begin
                cmd.last = (ROW_IDX_W'(i_reg) == no - 1'b1);
                if (stat.out_free)
                begin
                    cmd.op = OP_FOUT;
                    if (cmd.last)
                        state_next = S_IDLE;
                    else
                        i_next = i_reg + 1'b1;
                end
            end
            S_BWD:
            begin
                cmd.op    = OP_BWD;
                cmd.row   = ROW_IDX_W'(row_reg);
                cmd.first = (j_reg == '0);
                cmd.zero  = (row_reg == '0);
                cmd.inr   = (COL_IDX_W'(j_reg) < ni);
                if (ph_reg != 2'd2)
                    ph_next = ph_reg + 1'b1;
                else
                begin
                    ph_next = '0;
                    if (COL_IDX_W'(j_reg) == jend)
                        state_next = S_IDLE;
                    else
                        j_next = j_reg + 1'b1;
                end
            end
            S_IGRD:
            begin
                cmd.col = COL_IDX_W'(col_reg);
                if (ph_reg == 2'd0)
                    ph_next = 2'd1;
                else if (stat.out_free)
                begin
                    cmd.op     = OP_IGRD;
                    state_next = S_IDLE;
                end
            end
            S_UPD:
            begin
                cmd.op  = OP_UPD;
                cmd.inr = (ROW_IDX_W'(i_reg) < no) && (COL_IDX_W'(j_reg) < ni);
                if (ph_reg != 2'd2)
                    ph_next = ph_reg + 1'b1;
                else
                begin
                    ph_next = '0;
                    if (j_reg == CIW'(MAX_IN - 1))
                    begin
                        j_next = '0;
                        if (i_reg == RIW'(MAX_OUT - 1))
                        begin
                            i_next     = '0;
                            state_next = S_UBIAS;
                        end
                        else
                            i_next = i_reg + 1'b1;
                    end
                    else
                        j_next = j_reg + 1'b1;
                end
            end
            S_UBIAS:
            begin
                cmd.op  = OP_UBIAS;
                cmd.inr = (ROW_IDX_W'(i_reg) < no);
                if (ph_reg == 2'd0)
                    ph_next = 2'd1;
                else
                begin
                    ph_next = '0;
                    if (i_reg == RIW'(MAX_OUT - 1))
                    begin
                        i_next     = '0;
                        state_next = S_DONE;
                    end
                    else
                        i_next = i_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                cmd.last = 1'b1;
                if (stat.out_free)
                begin
                    cmd.op     = OP_DONE;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            i_reg        <= '0;
            j_reg        <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            ph_reg       <= '0;
            in_size_reg  <= 11'd784;
            out_size_reg <= 5'd10;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            ph_reg    <= ph_next;
            if (cfg_we && cfg_index == CFG_IN_SIZE)
                in_size_reg <= cfg_data[10:0];
            if (cfg_we && cfg_index == CFG_OUT_SIZE)
                out_size_reg <= cfg_data[4:0];
        end
    end

    `DLTE_ASSERT(a_fout_needs_room, clk, rst_n, (cmd.op == OP_FOUT) |-> stat.out_free)
    `DLTE_ASSERT_NEVER(a_phase_range, clk, rst_n, ph_reg == 2'd3)
    `DLTE_ASSERT(a_fwd_start, clk, rst_n, (acc_req && req == REQ_FWD && col_ext < ni) |=> (state_reg == S_FWD && i_reg == '0))
endmodule
`default_nettype wire

### src/dlte_datapath.sv
// Datapath of the dense layer engine: stores, multipliers, accumulators, result register.
`default_nettype none
module dlte_datapath
    import dlte_pkg::*;
#(
    parameter int MAX_IN  = DEF_MAX_IN,
    parameter int MAX_OUT = DEF_MAX_OUT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmd_t              cmd,
    output stat_t                  stat,
    input  wire logic signed [15:0] val_in,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [15:0]       cfg_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [1:0]             out_kind,
    output logic [9:0]             out_index,
    output logic signed [15:0]     out_result,
    output logic                   out_last
);
    localparam int RW     = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
    localparam int CW     = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;
    localparam int WDEPTH = MAX_OUT * (1 << CW);

    logic signed [VAL_W-1:0] w_mem  [WDEPTH];
    logic signed [WG_W-1:0]  wg_mem [WDEPTH];
    logic signed [VAL_W-1:0] sv_mem [MAX_IN];
    logic signed [ACC_W-1:0] ig_mem [MAX_IN];

    logic signed [ACC_W-1:0] acc_reg   [MAX_OUT];
    logic signed [WG_W-1:0]  bgrad_reg [MAX_OUT];
    logic signed [VAL_W-1:0] bias_reg  [MAX_OUT];

    logic signed [VAL_W-1:0]   w_rd_reg, sv_rd_reg, val_reg;
    logic signed [WG_W-1:0]    wg_rd_reg, prod_w_reg, prod_x_reg;
    logic signed [ACC_W-1:0]   ig_rd_reg;
    logic signed [PRODU_W-1:0] prod_u_reg;
    logic [LR_W-1:0]           lr_reg;

    logic                 out_valid_reg, out_last_reg;
    logic [1:0]           out_kind_reg;
    logic [9:0]           out_index_reg;
    logic signed [15:0]   out_result_reg;

    logic [RW+CW-1:0] wadr;
    logic [CW-1:0]    cadr;
    logic [RW-1:0]    radr;
    logic             w_we, wg_we, ig_we, sv_we, out_free;
    logic signed [VAL_W-1:0] w_wd;
    logic signed [WG_W-1:0]  wg_wd;
    logic signed [ACC_W-1:0] ig_wd, ig_base;
    logic signed [WG_W:0]    wg_sum;
    logic signed [ACC_W+1:0] f_sum, ig_rnd;
    logic signed [PRODU_W:0] uw_rnd, ub_rnd;
    logic signed [16:0]      lr_s;
    logic signed [15:0]      f_res, ig_res, upd_w, upd_b;

    assign wadr = {cmd.row[RW-1:0], cmd.col[CW-1:0]};
    assign cadr = cmd.col[CW-1:0];
    assign radr = cmd.row[RW-1:0];
    assign lr_s = $signed({1'b0, lr_reg});
    assign out_free      = !out_valid_reg || out_ready;
    assign stat.out_free = out_free;

    // rounding to nearest, ties up: add half, then arithmetic shift
    always_comb
    begin
        f_sum  = (ACC_W+2)'(acc_reg[radr]) + (ACC_W+2)'($signed({bias_reg[radr], 12'd0}))
                 + (ACC_W+2)'(2048);
        f_res  = sat16(64'(f_sum >>> 12));
        ig_rnd = (ACC_W+2)'(ig_rd_reg) + (ACC_W+2)'(2048);
        ig_res = sat16(64'(ig_rnd >>> 12));
        uw_rnd = (PRODU_W+1)'(prod_u_reg) + (PRODU_W+1)'(134217728);
        upd_w  = sat16(64'(w_rd_reg) - 64'(uw_rnd >>> 28));
        ub_rnd = (PRODU_W+1)'(prod_u_reg) + (PRODU_W+1)'(32768);
        upd_b  = sat16(64'(bias_reg[radr]) - 64'(ub_rnd >>> 16));
        wg_sum = (WG_W+1)'(wg_rd_reg) + (WG_W+1)'(prod_x_reg);
        ig_base = cmd.zero ? '0 : ig_rd_reg;
    end

    always_comb
    begin
        w_we  = 1'b0;
        w_wd  = val_in;
        wg_we = 1'b0;
        wg_wd = '0;
        ig_we = 1'b0;
        ig_wd = '0;
        sv_we = 1'b0;
        unique case (cmd.op)
            OP_LDW:
                w_we = 1'b1;
            OP_FWD:
                sv_we = (cmd.phase == 2'd0) && cmd.first;
            OP_BWD:
                if (cmd.phase == 2'd2)
                begin
                    ig_we = 1'b1;
                    if (cmd.inr)
                    begin
                        wg_we = 1'b1;
                        wg_wd = sat32(64'(wg_sum));
                        ig_wd = ig_base + ACC_W'(prod_w_reg);
                    end
                end
            OP_UPD:
                if (cmd.phase == 2'd2)
                begin
                    wg_we = 1'b1;
                    w_we  = cmd.inr;
                    w_wd  = upd_w;
                end
            OP_CLR:
            begin
                wg_we = 1'b1;
                ig_we = (cmd.row == '0);
            end
            default: ;
        endcase
    end

    // single-port stores with registered read
    always_ff @(posedge clk)
    begin
        if (w_we)
            w_mem[wadr] <= w_wd;
        w_rd_reg <= w_mem[wadr];
    end

    always_ff @(posedge clk)
    begin
        if (wg_we)
            wg_mem[wadr] <= wg_wd;
        wg_rd_reg <= wg_mem[wadr];
    end

    always_ff @(posedge clk)
    begin
        if (sv_we)
            sv_mem[cadr] <= val_reg;
        sv_rd_reg <= sv_mem[cadr];
    end

    always_ff @(posedge clk)
    begin
        if (ig_we)
            ig_mem[cadr] <= ig_wd;
        ig_rd_reg <= ig_mem[cadr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
            val_reg <= val_in;
        if (cmd.op == OP_LDB)
            bias_reg[radr] <= val_in;
        else if (cmd.op == OP_UBIAS && cmd.phase == 2'd1 && cmd.inr)
            bias_reg[radr] <= upd_b;
        if ((cmd.op == OP_FWD || cmd.op == OP_BWD) && cmd.phase == 2'd1)
            prod_w_reg <= WG_W'(w_rd_reg) * WG_W'(val_reg);
        if (cmd.op == OP_BWD && cmd.phase == 2'd1)
            prod_x_reg <= WG_W'(sv_rd_reg) * WG_W'(val_reg);
        if (cmd.op == OP_UPD && cmd.phase == 2'd1)
            prod_u_reg <= PRODU_W'(lr_s) * PRODU_W'(wg_rd_reg);
        else if (cmd.op == OP_UBIAS && cmd.phase == 2'd0)
            prod_u_reg <= PRODU_W'(lr_s) * PRODU_W'(bgrad_reg[radr]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_OUT; k++)
            begin
                acc_reg[k]   <= '0;
                bgrad_reg[k] <= '0;
            end
            lr_reg <= 16'd655;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_LR)
                lr_reg <= cfg_data;
            if (cmd.op == OP_FWD && cmd.phase == 2'd0 && cmd.first && cmd.zero)
            begin
                for (int k = 0; k < MAX_OUT; k++)
                    acc_reg[k] <= '0;
            end
            else if (cmd.op == OP_FWD && cmd.phase == 2'd2)
                acc_reg[radr] <= acc_reg[radr] + ACC_W'(prod_w_reg);
            if (cmd.op == OP_BWD && cmd.phase == 2'd0 && cmd.first)
                bgrad_reg[radr] <= sat32(64'(bgrad_reg[radr]) + 64'(val_reg));
            else if (cmd.op == OP_UBIAS && cmd.phase == 2'd1)
                bgrad_reg[radr] <= '0;
        end
    end

    // result register: load a new transfer whenever the slot is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == OP_FOUT || cmd.op == OP_IGRD || cmd.op == OP_DONE)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_FOUT:
            begin
                out_kind_reg   <= KIND_FWD;
                out_index_reg  <= 10'(cmd.row);
                out_result_reg <= f_res;
                out_last_reg   <= cmd.last;
            end
            OP_IGRD:
            begin
                out_kind_reg   <= KIND_IGRAD;
                out_index_reg  <= cmd.col[9:0];
                out_result_reg <= ig_res;
                out_last_reg   <= 1'b1;
            end
            OP_DONE:
            begin
                out_kind_reg   <= KIND_DONE;
                out_index_reg  <= '0;
                out_result_reg <= '0;
                out_last_reg   <= 1'b1;
            end
            default: ;
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign out_index  = out_index_reg;
    assign out_result = out_result_reg;
    assign out_last   = out_last_reg;
endmodule
`default_nettype wire

### src/dense_layer_train_engine.sv
// Dense layer engine: forward pass, backward pass and SGD update in Q4.12 fixed point.
//
// Input stream (s_*): one request per transfer; s_tuser carries the request kind,
// s_tdata the row, column and value. Output stream (m_*): forward outputs, input
// gradients and the update-done marker; m_tuser is the kind, m_tlast marks the
// final result of a run. Registers are written through cfg_we/cfg_index/cfg_data.
// One request is processed at a time; s_tready is high only while the sequencer
// is idle, where each request is accepted. Every memory access goes through a
// registered single-port store, so a swept element passes through read, multiply
// and write steps. Loading a weight or bias completes on acceptance; a forward
// element sweeps out_size output rows, then emits one result per output row on
// the last column; a backward element sweeps in_size columns (all MAX_IN for
// row 0, which also clears unused gradient columns); an input gradient read
// returns one result; an update sweeps all MAX_OUT*MAX_IN weight positions, then
// every bias. After reset a clearing pass over all weight positions zeroes the
// gradient stores before the first request is taken; configuration writes are
// taken meanwhile. A result waits in the output register while m_tready is low;
// the sequencer holds until that slot frees.
`default_nettype none
module dense_layer_train_engine
    import dlte_pkg::*;
#(
    parameter int MAX_IN  = DEF_MAX_IN,
    parameter int MAX_OUT = DEF_MAX_OUT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // row[3:0], column[13:4], value[29:14], zero pad
    input  wire logic [2:0]  s_tuser,   // req_type[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // index[9:0], result[25:10], zero pad
    output logic [1:0]       m_tuser,   // kind[1:0]
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    cmd_t               cmd;
    stat_t              stat;
    logic [9:0]         out_index;
    logic signed [15:0] out_result;
    logic signed [15:0] value;

    assign value = $signed(s_tdata[29:14]);

    dlte_ctrl #(
        .MAX_IN  (MAX_IN),
        .MAX_OUT (MAX_OUT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .req       (s_tuser),
        .row_in    (s_tdata[3:0]),
        .col_in    (s_tdata[13:4]),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .cmd       (cmd)
    );

    dlte_datapath #(
        .MAX_IN  (MAX_IN),
        .MAX_OUT (MAX_OUT)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .val_in     (value),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (m_tuser),
        .out_index  (out_index),
        .out_result (out_result),
        .out_last   (m_tlast)
    );

    assign m_tdata = {6'd0, out_result, out_index};
endmodule
`default_nettype wire
